// ----- src/dbtcs_pkg.sv -----
package dbtcs_pkg;

    localparam int FRAME_DIM_W = 9;
    localparam int COORD_W     = 8;
    localparam int COLOR_W     = 24;
    localparam int DEPTH_IN_W  = 16;
    // x + y * width stays below 2^17 for 8-bit coordinates and a 9-bit width
    localparam int IDX_W       = 17;
    localparam int AREA_W      = 2 * FRAME_DIM_W;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAR_DEPTH    = 2'd3;

    localparam logic [FRAME_DIM_W-1:0] FRAME_WIDTH_RST  = 9'd256;
    localparam logic [FRAME_DIM_W-1:0] FRAME_HEIGHT_RST = 9'd256;
    localparam logic [COLOR_W-1:0]     BACKGROUND_RST   = 24'd0;
    localparam logic [DEPTH_IN_W-1:0]  FAR_DEPTH_RST    = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_DEPTH = 2'd0,
        KIND_COLOR = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [COORD_W-1:0]    pixel_x;
        logic [COORD_W-1:0]    pixel_y;
        logic [DEPTH_IN_W-1:0] depth_value;
        logic [COLOR_W-1:0]    color_in;
    } t_in_word;

    typedef struct packed {
        logic               in_range;
        logic               depth_pass;
        logic [COLOR_W-1:0] color_out;
        logic               pixel_drawn;
    } t_out_word;

    typedef struct packed {
        logic accept;
        logic clr_run;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic kind_clear;
        logic clr_last;
        logic out_free;
    } t_ctrl_status;

endpackage

// ----- src/dbtcs_ram.sv -----
module dbtcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/dbtcs_ctrl.sv -----
module dbtcs_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  dbtcs_pkg::t_ctrl_status i_status,
    output dbtcs_pkg::t_ctrl_cmd    o_cmd,
    output logic                    o_in_stall
);
    import dbtcs_pkg::*;

    typedef enum logic [3:0] {
        S_INIT  = 4'b0001,
        S_IDLE  = 4'b0010,
        S_CLEAR = 4'b0100,
        S_EXEC  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.clr_run = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_status.kind_clear ? S_CLEAR : S_EXEC;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_run = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold until the output register can take the word
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ----- src/dbtcs_datapath.sv -----
module dbtcs_datapath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int DEPTH_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  dbtcs_pkg::t_in_word                    i_in_word,
    input  dbtcs_pkg::t_ctrl_cmd                   i_cmd,
    output dbtcs_pkg::t_ctrl_status                o_status,
    input  logic                                   i_out_stall,
    output logic                                   o_out_valid,
    output dbtcs_pkg::t_out_word                   o_out_word,
    input  logic                                   i_cfg_write,
    input  logic [dbtcs_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [dbtcs_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import dbtcs_pkg::*;

    localparam int          STORE   = MAX_WIDTH * MAX_HEIGHT;
    localparam logic [31:0] STORE_SIZE = 32'(STORE);
    localparam int          ADDR_W  = (STORE > 1) ? $clog2(STORE) : 1;

    // configuration
    logic [FRAME_DIM_W-1:0] r_frame_width;
    logic [FRAME_DIM_W-1:0] r_frame_height;
    logic [COLOR_W-1:0]     r_background;
    logic [DEPTH_IN_W-1:0]  r_far_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_background   <= BACKGROUND_RST;
            r_far_depth    <= FAR_DEPTH_RST;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FRAME_DIM_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FRAME_DIM_W-1:0];
                CFG_BACKGROUND:   r_background   <= i_cfg_data[COLOR_W-1:0];
                CFG_FAR_DEPTH:    r_far_depth    <= i_cfg_data[DEPTH_IN_W-1:0];
            endcase
        end
    end

    // linear index and frame area, registered with the accepted word
    logic [IDX_W-1:0]  idx_y;
    logic [IDX_W-1:0]  idx_comb;
    logic [AREA_W-1:0] area_comb;

    assign idx_y     = IDX_W'(i_in_word.pixel_y) * IDX_W'(r_frame_width);
    assign idx_comb  = idx_y + IDX_W'(i_in_word.pixel_x);
    assign area_comb = AREA_W'(r_frame_width) * AREA_W'(r_frame_height);

    t_in_word          r_in;
    logic [IDX_W-1:0]  r_idx;
    logic [AREA_W-1:0] r_area;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in   <= i_in_word;
            r_idx  <= idx_comb;
            r_area <= area_comb;
        end
    end

    // clear sweep; reset starts one with the reset-time values
    logic [ADDR_W-1:0]     r_clr_cnt;
    logic [DEPTH_BITS-1:0] r_clr_depth;
    logic [COLOR_W-1:0]    r_clr_color;
    logic                  clr_last;

    assign clr_last = (r_clr_cnt == ADDR_W'(STORE - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_clr_depth <= DEPTH_BITS'(FAR_DEPTH_RST);
            r_clr_color <= BACKGROUND_RST;
        end else begin
            if (i_cmd.clr_run) begin
                r_clr_cnt <= clr_last ? '0 : r_clr_cnt + 1'b1;
            end
            if (i_cmd.accept && i_in_word.kind == KIND_CLEAR) begin
                r_clr_depth <= DEPTH_BITS'(r_far_depth);
                r_clr_color <= r_background;
            end
        end
    end

    // store access
    logic [ADDR_W-1:0]     ram_addr;
    logic [DEPTH_BITS-1:0] depth_rd;
    logic [COLOR_W-1:0]    color_rd;
    logic [DEPTH_BITS-1:0] frag_depth;
    logic                  ok;
    logic                  pass;
    logic                  depth_we;
    logic                  color_we;

    always_comb begin
        if (i_cmd.accept) begin
            ram_addr = ADDR_W'(idx_comb);
        end else if (i_cmd.clr_run) begin
            ram_addr = r_clr_cnt;
        end else begin
            ram_addr = ADDR_W'(r_idx);
        end
    end

    assign frag_depth = DEPTH_BITS'(r_in.depth_value);
    assign ok   = (r_in.kind != KIND_CLEAR) && (AREA_W'(r_idx) < r_area)
                  && (32'(r_idx) < STORE_SIZE);
    assign pass = (r_in.kind == KIND_DEPTH) && ok && (depth_rd > frag_depth);

    assign depth_we = i_cmd.clr_run || (i_cmd.finish && pass);
    assign color_we = i_cmd.clr_run || (i_cmd.finish && ok && r_in.kind == KIND_COLOR);

    dbtcs_ram #(
        .WIDTH (DEPTH_BITS),
        .DEPTH (STORE),
        .AW    (ADDR_W)
    ) u_depth_ram (
        .i_clk   (i_clk),
        .i_we    (depth_we),
        .i_re    (i_cmd.accept),
        .i_addr  (ram_addr),
        .i_wdata (i_cmd.clr_run ? r_clr_depth : frag_depth),
        .o_rdata (depth_rd)
    );

    dbtcs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (STORE),
        .AW    (ADDR_W)
    ) u_color_ram (
        .i_clk   (i_clk),
        .i_we    (color_we),
        .i_re    (i_cmd.accept),
        .i_addr  (ram_addr),
        .i_wdata (i_cmd.clr_run ? r_clr_color : r_in.color_in),
        .o_rdata (color_rd)
    );

    // output register
    logic      r_out_valid;
    t_out_word r_out_word;
    logic      is_read;

    assign is_read = ok && (r_in.kind == KIND_READ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_word.in_range    <= ok;
            r_out_word.depth_pass  <= pass;
            r_out_word.color_out   <= is_read ? color_rd : '0;
            r_out_word.pixel_drawn <= is_read && (color_rd != r_background);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign o_status.kind_clear = (i_in_word.kind == KIND_CLEAR);
    assign o_status.clr_last   = clr_last;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

endmodule

// ----- src/depth_buffer_test_and_color_store.sv -----
// Depth test, color write and read: the store is read as the input word is taken,
// then compare and write happen and the result word is registered in the EXEC state,
// which waits while the output is stalled; no new word is taken until then.
// Clear: one depth and color entry swept per cycle over all MAX_WIDTH*MAX_HEIGHT entries.
// Reset (synchronous, active low) starts a clearing pass that writes far depth 65535
// and background 0; input stalls during it, configuration writes are taken at any time.
module depth_buffer_test_and_color_store #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int DEPTH_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  dbtcs_pkg::t_in_word               i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output dbtcs_pkg::t_out_word              o_out_word,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dbtcs_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [dbtcs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import dbtcs_pkg::*;

    t_ctrl_cmd    cmd;
    t_ctrl_status status;

    assign o_cfg_ready = 1'b1;

    dbtcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    dbtcs_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_cfg_write (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

// ----- src/dbtcs_checker.sv -----
module dbtcs_props (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input dbtcs_pkg::t_in_word  i_in_word,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input dbtcs_pkg::t_out_word o_out_word
);
    import dbtcs_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // one word in flight: input stalls right after a word is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken twice in a row");

    // a new result only shows up while the block is busy with a word
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without work in progress");

    // out-of-range and clear words carry no pass, color or drawn flag
    a_range_gates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.in_range |->
            !o_out_word.depth_pass && !o_out_word.pixel_drawn
            && o_out_word.color_out == '0)
        else $error("flags set on out-of-range result");

endmodule

bind depth_buffer_test_and_color_store dbtcs_props u_dbtcs_checker (.*);
